// File: hw/rtl/asc_pkg.sv
// constants, types and keyword table for the assembler symbol classifier
`default_nettype none
package asc_pkg;

   localparam int KwCount  = 8;
   localparam int KwMaxLen = 7;
   localparam int PosWidth = 5;
   localparam int LenWidth = 5;

   localparam logic [PosWidth-1:0] PosMax       = '1;
   localparam logic [LenWidth-1:0] MaxLenReset  = 5'd6;
   localparam logic [7:0]          CharTerm     = 8'h00;
   localparam logic [7:0]          CharUpperA   = 8'd65;
   localparam logic [7:0]          CharUpperZ   = 8'd90;

   localparam int CsrAddrWidth = 2;
   localparam int CsrDataWidth = 32;
   localparam logic [CsrAddrWidth-1:0] CsrAddrMaxLen = 2'd0;

   typedef enum logic [3:0] {
      VERDICT_INVALID = 4'd0,
      VERDICT_SYMBOL  = 4'd1,
      VERDICT_BYTE    = 4'd2,
      VERDICT_END     = 4'd3,
      VERDICT_EXPORTS = 4'd4,
      VERDICT_RESB    = 4'd5,
      VERDICT_RESR    = 4'd6,
      VERDICT_RESW    = 4'd7,
      VERDICT_START   = 4'd8,
      VERDICT_WORD    = 4'd9
   } verdict_type;

   typedef struct packed {
      logic       accept;
      logic [7:0] symbol_char;
   } char_word_type;

   localparam logic [7:0] KwText [KwCount][KwMaxLen] = '{
      '{"B", "Y", "T", "E", 8'h00, 8'h00, 8'h00},
      '{"E", "N", "D", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"E", "X", "P", "O", "R", "T", "S"},
      '{"R", "E", "S", "B", 8'h00, 8'h00, 8'h00},
      '{"R", "E", "S", "R", 8'h00, 8'h00, 8'h00},
      '{"R", "E", "S", "W", 8'h00, 8'h00, 8'h00},
      '{"S", "T", "A", "R", "T", 8'h00, 8'h00},
      '{"W", "O", "R", "D", 8'h00, 8'h00, 8'h00}
   };

   localparam logic [PosWidth-1:0] KwLen [KwCount] = '{
      5'd4, 5'd3, 5'd7, 5'd4, 5'd4, 5'd4, 5'd5, 5'd4
   };

endpackage
`default_nettype wire

// File: hw/rtl/asc_if.sv
// valid/ready channel interfaces for label characters and verdicts
`default_nettype none
interface asc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] symbol_char;

   modport source (output valid, output symbol_char, input ready);
   modport sink (input valid, input symbol_char, output ready);
endinterface

interface asc_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] verdict;

   modport source (output valid, output verdict, input ready);
   modport sink (input valid, input verdict, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/assembler_symbol_classifier.sv
// top level of the assembler symbol classifier
// usage:
//   req_chan carries one label character per word; a zero byte ends the label.
//   rsp_chan carries one verdict word per label, issued for the terminator:
//   0 invalid, 1 valid symbol, 2..9 the directives BYTE END EXPORTS RESB RESR
//   RESW START WORD.
//   csr_* is an apb write/read port; register 0 holds max_symbol_length.
//   throughput: one character per cycle while rsp_chan is not stalled, set by the single label state update.
//   the verdict appears in the result register in the cycle after the
//   terminator is accepted.
//   a stalled rsp_chan holds the verdict and stops req_chan until the verdict
//   word is taken; req_chan is ready again in the cycle the verdict leaves.
//   reset clears the label state, empties the result register and sets
//   max_symbol_length to 6.
`default_nettype none
module assembler_symbol_classifier (
   input  wire                                  clock,
   input  wire                                  reset,
   asc_req_if.sink                              req_chan,
   asc_rsp_if.source                            rsp_chan,
   input  wire                                  csr_psel,
   input  wire                                  csr_penable,
   input  wire                                  csr_pwrite,
   input  wire  [asc_pkg::CsrAddrWidth-1:0]     csr_paddr,
   input  wire  [asc_pkg::CsrDataWidth-1:0]     csr_pwdata,
   output logic [asc_pkg::CsrDataWidth-1:0]     csr_prdata,
   output logic                                 csr_pready
);
   import asc_pkg::*;

   logic [LenWidth-1:0] max_len_ff, max_len_in;
   logic                rsp_valid_ff, rsp_valid_in;
   verdict_type         rsp_verdict_ff, rsp_verdict_in;
   verdict_type         verdict;
   char_word_type       char_word;
   logic                req_ready;
   logic                accept;
   logic                csr_write;

   assign req_ready      = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = req_ready;
   assign accept         = req_chan.valid && req_ready;

   assign char_word.accept      = accept;
   assign char_word.symbol_char = req_chan.symbol_char;

   asc_label_tracker u_tracker (
      .clock     (clock),
      .reset     (reset),
      .char_word (char_word),
      .max_len   (max_len_ff),
      .verdict   (verdict)
   );

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr == CsrAddrMaxLen) ?
                       {{(CsrDataWidth-LenWidth){1'b0}}, max_len_ff} : '0;

   always_comb begin
      max_len_in = max_len_ff;
      if (csr_write && csr_paddr == CsrAddrMaxLen) begin
         max_len_in = csr_pwdata[LenWidth-1:0];
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_verdict_in = rsp_verdict_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept && req_chan.symbol_char == CharTerm) begin
         rsp_valid_in   = 1'b1;
         rsp_verdict_in = verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= MaxLenReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         max_len_ff   <= max_len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_verdict_ff <= rsp_verdict_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.verdict = rsp_verdict_ff;

endmodule
`default_nettype wire

// File: hw/rtl/asc_label_tracker.sv
// per-label state: length, bad first char, forbidden chars, keyword prefix match
`default_nettype none
module asc_label_tracker (
   input  wire                                   clock,
   input  wire                                   reset,
   input  asc_pkg::char_word_type                char_word,
   input  wire  [asc_pkg::LenWidth-1:0]          max_len,
   output asc_pkg::verdict_type                  verdict
);
   import asc_pkg::*;

   logic [PosWidth-1:0] pos_ff, pos_in;
   logic                first_bad_ff, first_bad_in;
   logic                forbidden_ff, forbidden_in;
   logic [KwCount-1:0]  prefix_ff, prefix_in;

   logic [7:0]          c;
   logic                is_term;
   logic                is_forbidden;

   assign c       = char_word.symbol_char;
   assign is_term = (c == CharTerm);

   always_comb begin
      is_forbidden = c inside {8'd32, 8'd33, 8'd36, 8'd40, 8'd41, 8'd43, 8'd45, 8'd61, 8'd64};
   end

   always_comb begin
      pos_in       = pos_ff;
      first_bad_in = first_bad_ff;
      forbidden_in = forbidden_ff;
      prefix_in    = prefix_ff;
      if (char_word.accept) begin
         if (is_term) begin
            pos_in       = '0;
            first_bad_in = 1'b0;
            forbidden_in = 1'b0;
            prefix_in    = '1;
         end else begin
            if (pos_ff == '0 && !(c inside {[CharUpperA:CharUpperZ]})) begin
               first_bad_in = 1'b1;
            end
            if (is_forbidden) begin
               forbidden_in = 1'b1;
            end
            for (int k = 0; k < KwCount; k++) begin
               if (!(pos_ff < KwLen[k] && KwText[k][pos_ff[2:0]] == c)) begin
                  prefix_in[k] = 1'b0;
               end
            end
            if (pos_ff != PosMax) begin
               pos_in = pos_ff + 1'b1;
            end
         end
      end
   end

   always_comb begin
      logic found;
      found   = 1'b0;
      verdict = VERDICT_INVALID;
      for (int k = 0; k < KwCount; k++) begin
         if (!found && prefix_ff[k] && pos_ff == KwLen[k]) begin
            verdict = verdict_type'(4'(VERDICT_BYTE) + 4'(k));
            found   = 1'b1;
         end
      end
      if (!found && pos_ff != '0 && !first_bad_ff && !forbidden_ff && pos_ff <= max_len) begin
         verdict = VERDICT_SYMBOL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         first_bad_ff <= 1'b0;
         forbidden_ff <= 1'b0;
         prefix_ff    <= '1;
      end else begin
         pos_ff       <= pos_in;
         first_bad_ff <= first_bad_in;
         forbidden_ff <= forbidden_in;
         prefix_ff    <= prefix_in;
      end
   end

endmodule
`default_nettype wire
